/* src/prm_pkg.sv */
// prm_pkg: shared types, codes and constants for the pending range merger
// used by prm_ctrl, prm_datapath and pending_range_merger; depends on nothing
package prm_pkg;

    // default number of table entries
    localparam int TABLE_DEPTH = 16;

    // field widths
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 32;
    localparam int IDX_W   = 4;
    localparam int PHYS_W  = 29;
    localparam int SLEN_W  = 30;
    localparam int CNT_W   = 5;
    // merged end needs one bit above the stored length
    localparam int END_W   = 31;
    localparam int SUM_W   = 33;

    // top of the physical space
    localparam logic [SUM_W-1:0] PHYS_TOP = 33'h0_2000_0000;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_QUEUE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INVAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [IDX_W-1:0]  index;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] entry_base;
        logic [SLEN_W-1:0] entry_length;
        logic [CNT_W-1:0]  pending_count;
        logic              reset_pending;
        logic              overflowed;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted request
        logic rd_en;      // read the table
        logic rd_item;    // read address from the request index
        logic clr;        // empty the table
        logic set_flag;
        logic clr_flag;
        logic set_ovf;
        logic scan_step;  // compare one stored entry
        logic append;     // store the merged range
        logic emit;       // load the response register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              len_zero;
        logic              bound_ovf;
        logic              count_zero;
        logic              scan_last;
        logic              rsp_free;
    } dp_status_t;

endpackage

/* src/prm_ctrl.sv */
// prm_ctrl: sequencing state machine for the pending range merger
// depends on prm_pkg for the command, status and kind codes
module prm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  prm_pkg::dp_status_t    status,
    output prm_pkg::ctrl_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                case (status.kind)
                    prm_pkg::KIND_QUEUE:
                    begin
                        if (status.len_zero)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (status.bound_ovf)
                        begin
                            cmd.clr      = 1'b1;
                            cmd.set_flag = 1'b1;
                            cmd.set_ovf  = 1'b1;
                        end
                        else
                        begin
                            // fetch entry zero ahead of the scan
                            cmd.rd_en  = 1'b1;
                            state_next = status.count_zero ? S_APPEND : S_SCAN;
                        end
                    end
                    prm_pkg::KIND_INVAL:
                    begin
                        cmd.clr      = 1'b1;
                        cmd.set_flag = 1'b1;
                    end
                    prm_pkg::KIND_READ:
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_item = 1'b1;
                    end
                    prm_pkg::KIND_RESET:
                    begin
                        cmd.clr      = 1'b1;
                        cmd.clr_flag = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.rd_en     = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.rsp_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/prm_datapath.sv */
// prm_datapath: range table memory, merge compare unit, counters and response register
// depends on prm_pkg for the payload structs, command and status structs and constants
module prm_datapath #(
    parameter int TABLE_DEPTH = prm_pkg::TABLE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  prm_pkg::req_t          req,
    input  prm_pkg::ctrl_cmd_t     cmd,
    output prm_pkg::dp_status_t    status,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output prm_pkg::rsp_t          rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // table storage, contents undefined until written
    logic [prm_pkg::PHYS_W-1:0] start_mem [TABLE_DEPTH];
    logic [prm_pkg::SLEN_W-1:0] len_mem   [TABLE_DEPTH];

    // captured request
    logic [prm_pkg::KIND_W-1:0] kind_reg;
    logic [prm_pkg::IDX_W-1:0]  idx_reg;
    logic                       len_zero_reg;
    logic                       bound_reg;

    // merge state
    logic [prm_pkg::PHYS_W-1:0] mstart_reg;
    logic [prm_pkg::END_W-1:0]  mend_reg;
    logic                       merged_reg;
    logic [CW-1:0]              keep_reg;
    logic [AW-1:0]              scan_idx_reg;

    // table state
    logic [CW-1:0]              count_reg;
    logic                       flag_reg;
    logic                       ovf_reg;

    // read data
    logic [prm_pkg::PHYS_W-1:0] rd_start_reg;
    logic [prm_pkg::SLEN_W-1:0] rd_len_reg;

    // response register
    prm_pkg::rsp_t              rsp_reg;
    logic                       rsp_valid_reg;

    logic [prm_pkg::SUM_W-1:0]  req_end;
    logic [prm_pkg::END_W-1:0]  rs_ext;
    logic [prm_pkg::END_W-1:0]  re_ext;
    logic                       overlap;
    logic                       full;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [prm_pkg::PHYS_W-1:0] wr_start;
    logic [prm_pkg::SLEN_W-1:0] wr_len;
    logic                       read_hit;
    logic                       rsp_free;

    // exact end of the new range
    assign req_end = prm_pkg::SUM_W'(req.address[prm_pkg::PHYS_W-1:0])
                   + prm_pkg::SUM_W'(req.length);

    // compare the fetched entry against the merged range
    assign rs_ext  = prm_pkg::END_W'(rd_start_reg);
    assign re_ext  = rs_ext + prm_pkg::END_W'(rd_len_reg);
    assign overlap = !((mend_reg < rs_ext)
                     || (prm_pkg::END_W'(mstart_reg) > re_ext));
    assign full    = !merged_reg && (keep_reg >= DEPTH_C);

    // memory port addressing
    always_comb
    begin
        if (cmd.rd_item)
        begin
            rd_addr = AW'(idx_reg);
        end
        else if (cmd.scan_step)
        begin
            rd_addr = scan_idx_reg + AW'(1);
        end
        else
        begin
            rd_addr = scan_idx_reg;
        end
        wr_en    = (cmd.scan_step && !overlap) || (cmd.append && !full);
        wr_addr  = keep_reg[AW-1:0];
        wr_start = cmd.append ? mstart_reg : rd_start_reg;
        wr_len   = cmd.append
                 ? prm_pkg::SLEN_W'(mend_reg - prm_pkg::END_W'(mstart_reg))
                 : rd_len_reg;
    end

    // table memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_addr] <= wr_start;
            len_mem[wr_addr]   <= wr_len;
        end
        if (cmd.rd_en)
        begin
            rd_start_reg <= start_mem[rd_addr];
            rd_len_reg   <= len_mem[rd_addr];
        end
    end

    // request capture and merge registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= req.kind;
            idx_reg      <= req.index;
            len_zero_reg <= (req.length == '0);
            bound_reg    <= (req_end > prm_pkg::PHYS_TOP);
            mstart_reg   <= req.address[prm_pkg::PHYS_W-1:0];
            mend_reg     <= req_end[prm_pkg::END_W-1:0];
            merged_reg   <= 1'b0;
            keep_reg     <= '0;
            scan_idx_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + AW'(1);
                if (overlap)
                begin
                    if (rd_start_reg < mstart_reg)
                    begin
                        mstart_reg <= rd_start_reg;
                    end
                    if (re_ext > mend_reg)
                    begin
                        mend_reg <= re_ext;
                    end
                    merged_reg <= 1'b1;
                end
                else
                begin
                    keep_reg <= keep_reg + CW'(1);
                end
            end
            if (cmd.set_ovf || (cmd.append && full))
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // entry count and reset flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= full ? '0 : keep_reg + CW'(1);
            end
            if (cmd.set_flag || (cmd.append && full))
            begin
                flag_reg <= 1'b1;
            end
            else if (cmd.clr_flag)
            begin
                flag_reg <= 1'b0;
            end
        end
    end

    // response build
    assign read_hit = (kind_reg == prm_pkg::KIND_READ)
                    && (32'(idx_reg) < 32'(count_reg));
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.entry_base    <= read_hit
                ? {1'b1, {(prm_pkg::ADDR_W - prm_pkg::PHYS_W - 1){1'b0}}, rd_start_reg}
                : '0;
            rsp_reg.entry_length  <= read_hit ? rd_len_reg : '0;
            rsp_reg.pending_count <= prm_pkg::CNT_W'(count_reg);
            rsp_reg.reset_pending <= flag_reg;
            rsp_reg.overflowed    <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // status to the controller
    assign status.kind       = kind_reg;
    assign status.len_zero   = len_zero_reg;
    assign status.bound_ovf  = bound_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.scan_last  = ((CW'(scan_idx_reg) + CW'(1)) == count_reg);
    assign status.rsp_free   = rsp_free;

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above table depth");

    // response register is never overwritten while still held
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> rsp_free)
        else $error("response loaded while previous one pending");

    // scan only visits entries below the count
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (count_reg != '0) && (CW'(scan_idx_reg) < count_reg))
        else $error("scan beyond valid entries");

    // a stored merge leaves at least one entry
    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.append && !full) |=> (count_reg != '0))
        else $error("append left the table empty");

endmodule

/* src/pending_range_merger.sv */
// pending_range_merger: top level of the pending invalidation range table
// depends on prm_pkg, prm_ctrl and prm_datapath
//
//   channel   signals                        direction   contents
//   request   req_valid, req_ready, req      in          kind, address, length, index
//   response  rsp_valid, rsp_ready, rsp      out         entry, count, flags
//
// a queue request that reaches the table passes from acceptance through decode, an entry
// scan that reads and compacts one stored range per cycle through the table port (skipped
// when the table is empty), an append and the final state that loads the response
// reads, clears, resets and zero length or out of bound queue requests skip the scan and append
// one request is in work at a time; a new one is taken while the response register waits
// a stalled response holds the block in its final state until taken
// reset empties the table and clears the reset flag at once; no clearing pass
module pending_range_merger #(
    parameter int TABLE_DEPTH = prm_pkg::TABLE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  prm_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output prm_pkg::rsp_t  rsp
);

    prm_pkg::ctrl_cmd_t  cmd;
    prm_pkg::dp_status_t status;

    // sequencing
    prm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // table and merge logic
    prm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
